FILE: hdl/rcfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RC channel frame parser package
// Shared constants and the result record passed from the parser to the
// output register.
// ---------------------------------------------------------------------------
package rcfp_pkg;

    localparam int NUM_CHAN = 6;
    localparam int NUM_PAY  = 12;

    localparam logic [7:0] SYNC_BYTE = 8'hEE;
    localparam logic [7:0] END_BYTE  = 8'hFF;
    localparam logic [7:0] MAX_ID    = 8'd10;

    typedef logic [15:0] chan_width_t;

    typedef struct packed {
        logic                       done;
        logic [2:0]                 id;
        chan_width_t [NUM_CHAN-1:0] chan;
    } rcfp_result_t;

endpackage

FILE: hdl/rcfp_parse.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RC channel frame parser state
// Holds the parse phase, body count, frame id, stored body bytes and the
// latched channel durations; computes the result of one byte.
// ---------------------------------------------------------------------------
module rcfp_parse
    import rcfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output rcfp_result_t result
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_EE1   = 3'd1;
    localparam logic [2:0] PH_BODY  = 3'd2;
    localparam logic [2:0] PH_TRAIL = 3'd3;
    localparam logic [2:0] PH_FF1   = 3'd4;

    localparam logic [5:0] NUM_PAY_W = 6'(NUM_PAY);

    logic [2:0]                 phase_reg, phase_next;
    logic [5:0]                 count_reg, count_next;
    logic [3:0]                 id_reg, id_next;
    chan_width_t [NUM_CHAN-1:0] chan_reg, chan_next;
    logic [7:0]                 pay_reg [NUM_PAY];

    logic                       pay_we;
    logic [3:0]                 pay_idx;
    logic [3:0]                 id_eff;
    logic [5:0]                 len;
    logic [5:0]                 count_inc;
    logic                       done;
    logic [2:0]                 id_out;

    function automatic logic [5:0] body_len(input logic [3:0] id);
        logic [5:0] r;
        unique case (id)
            4'd1:    r = 6'd33;
            4'd2:    r = 6'd13;
            4'd3:    r = 6'd12;
            4'd5:    r = 6'd3;
            4'd6:    r = 6'd3;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        if (count_reg == 6'd0)
        begin
            id_eff = (rx_byte >= 8'd1 && rx_byte <= MAX_ID) ? rx_byte[3:0] : 4'd0;
        end
        else
        begin
            id_eff = id_reg;
        end
        len       = body_len(id_eff);
        count_inc = count_reg + 6'd1;
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        id_next    = id_reg;
        chan_next  = chan_reg;
        pay_we     = 1'b0;
        pay_idx    = 4'(count_reg - 6'd1);
        done       = 1'b0;
        id_out     = 3'd0;
        if (step)
        begin
            if (rx_byte == SYNC_BYTE && phase_reg == PH_HUNT)
            begin
                phase_next = PH_EE1;
            end
            else if (rx_byte == SYNC_BYTE && phase_reg == PH_EE1)
            begin
                phase_next = PH_BODY;
            end
            else if (phase_reg == PH_BODY)
            begin
                pay_we = (count_reg >= 6'd1) && (count_reg <= NUM_PAY_W);
                if (len == 6'd0)
                begin
                    phase_next = PH_HUNT;
                    count_next = 6'd0;
                    id_next    = 4'd0;
                end
                else if (count_inc == len)
                begin
                    phase_next = PH_TRAIL;
                    count_next = 6'd0;
                    id_next    = id_eff;
                end
                else
                begin
                    count_next = count_inc;
                    id_next    = id_eff;
                end
            end
            else if (rx_byte == END_BYTE && phase_reg == PH_TRAIL)
            begin
                phase_next = PH_FF1;
            end
            else if (rx_byte == END_BYTE && phase_reg == PH_FF1)
            begin
                if (id_reg == 4'd2)
                begin
                    for (int i = 0; i < NUM_CHAN; i++)
                    begin
                        chan_next[i] = {pay_reg[2*i+1], pay_reg[2*i]};
                    end
                end
                done       = 1'b1;
                id_out     = id_reg[2:0];
                phase_next = PH_HUNT;
                count_next = 6'd0;
                id_next    = 4'd0;
            end
            else
            begin
                phase_next = PH_HUNT;
                count_next = 6'd0;
                id_next    = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= 6'd0;
            id_reg    <= 4'd0;
            chan_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            id_reg    <= id_next;
            chan_reg  <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_reg[pay_idx] <= rx_byte;
        end
    end

    assign result.done = done;
    assign result.id   = id_out;
    assign result.chan = chan_next;

endmodule

FILE: hdl/rc_channel_frame_parser_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RC channel frame parser core
// A byte is taken into the input register; its result goes on to the result register.
// One byte per cycle when not stalled; input register, parser logic, result register.
// Reset: parser returns to hunting for header, latched channel durations clear
// to zero, both pipeline registers empty.
// ---------------------------------------------------------------------------
module rc_channel_frame_parser_core
    import rcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        frame_done,
    output logic [2:0]  frame_id,
    output logic [15:0] chan1_width,
    output logic [15:0] chan2_width,
    output logic [15:0] chan3_width,
    output logic [15:0] chan4_width,
    output logic [15:0] chan5_width,
    output logic [15:0] chan6_width
);

    logic         in_vld_reg;
    logic [7:0]   in_byte_reg;
    logic         out_vld_reg;
    rcfp_result_t res_reg;
    rcfp_result_t res_next;
    logic         adv_out;
    logic         load_in;

    assign adv_out    = in_vld_reg && (!out_vld_reg || !result_stall);
    assign load_in    = !in_vld_reg || adv_out;
    assign byte_stall = !load_in;

    rcfp_parse u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv_out),
        .rx_byte (in_byte_reg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (load_in)
            begin
                in_vld_reg <= byte_valid;
            end
            if (adv_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in && byte_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (adv_out)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign frame_done   = res_reg.done;
    assign frame_id     = res_reg.id;
    assign chan1_width  = res_reg.chan[0];
    assign chan2_width  = res_reg.chan[1];
    assign chan3_width  = res_reg.chan[2];
    assign chan4_width  = res_reg.chan[3];
    assign chan5_width  = res_reg.chan[4];
    assign chan6_width  = res_reg.chan[5];

endmodule
